FILE: src/oaht_pkg.sv
// Shared types, constants and helpers for the open-address hash table unit.
// Used by oaht_ctrl, oaht_dp and the top level open_address_hash_table_unit.
package oaht_pkg;

	localparam int KEY_W       = 31;
	localparam int PAY_IO_W    = 32;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int SLOT_OUT_W  = 10;
	localparam int COUNT_OUT_W = 11;
	localparam int COLL_W      = 32;
	localparam int S_TDATA_W   = 64;
	localparam int M_TDATA_W   = 88;

	// A 31-bit key times a 27-bit constant never exceeds 58 bits.
	localparam int HASH_W   = 58;
	localparam int HCONST_W = 27;

	localparam int DEF_TABLE_SLOTS  = 1024;
	localparam int DEF_PAYLOAD_BITS = 32;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	localparam logic [1:0] HSEL_C1 = 2'd0;
	localparam logic [1:0] HSEL_C2 = 2'd1;
	localparam logic [1:0] HSEL_C3 = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_HASH,
		S_REDUCE,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic used;
		logic tomb;
	} flags_t;

	typedef struct packed {
		logic                clear;
		logic                capture;
		logic                hash;
		logic                reduce;
		logic                read;
		logic                advance;
		logic                write_ins;
		logic                write_rem;
		logic                finish;
		logic [STATUS_W-1:0] fin_status;
		logic                emit;
	} cmd_t;

	typedef struct packed {
		logic              clear_done;
		logic [FUNC_W-1:0] func;
		logic              full;
		logic              hash_done;
		logic              reduce_done;
		logic              used;
		logic              tomb;
		logic              key_eq;
		logic              last;
		logic              out_free;
	} stat_t;

	function automatic logic [HCONST_W-1:0] hash_const(input logic [1:0] sel);
		logic [HCONST_W-1:0] c;
		case (sel)
			HSEL_C1: c = 27'd73856093;
			HSEL_C2: c = 27'd19349669;
			HSEL_C3: c = 27'd83492791;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: src/oaht_ctrl.sv
// Controller state machine of the hash table unit: sequences clearing, hashing,
// probing and result delivery. Depends on oaht_pkg; drives oaht_dp by commands.
module oaht_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  oaht_pkg::stat_t st,
	output oaht_pkg::cmd_t  cmd
);

	oaht_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oaht_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			oaht_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.clear_done) begin
					state_d = oaht_pkg::S_IDLE;
				end
			end
			oaht_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = oaht_pkg::S_START;
				end
			end
			oaht_pkg::S_START: begin
				case (st.func)
					oaht_pkg::FUNC_INSERT: begin
						if (st.full) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = oaht_pkg::STATUS_FULL;
							state_d        = oaht_pkg::S_DONE;
						end else begin
							state_d = oaht_pkg::S_HASH;
						end
					end
					oaht_pkg::FUNC_FIND, oaht_pkg::FUNC_REMOVE: begin
						state_d = oaht_pkg::S_HASH;
					end
					default: begin
						cmd.finish     = 1'b1;
						cmd.fin_status = oaht_pkg::STATUS_MISS;
						state_d        = oaht_pkg::S_DONE;
					end
				endcase
			end
			oaht_pkg::S_HASH: begin
				cmd.hash = 1'b1;
				if (st.hash_done) begin
					state_d = oaht_pkg::S_REDUCE;
				end
			end
			oaht_pkg::S_REDUCE: begin
				cmd.reduce = 1'b1;
				if (st.reduce_done) begin
					state_d = oaht_pkg::S_READ;
				end
			end
			oaht_pkg::S_READ: begin
				cmd.read = 1'b1;
				state_d  = oaht_pkg::S_CHECK;
			end
			oaht_pkg::S_CHECK: begin
				if (st.func == oaht_pkg::FUNC_INSERT) begin
					if (!st.used || st.tomb) begin
						cmd.write_ins  = 1'b1;
						cmd.finish     = 1'b1;
						cmd.fin_status = oaht_pkg::STATUS_OK;
						state_d        = oaht_pkg::S_DONE;
					end else if (st.last) begin
						cmd.finish     = 1'b1;
						cmd.fin_status = oaht_pkg::STATUS_FULL;
						state_d        = oaht_pkg::S_DONE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = oaht_pkg::S_READ;
					end
				end else begin
					// A slot that was never used ends the search.
					if (!st.used) begin
						cmd.finish     = 1'b1;
						cmd.fin_status = oaht_pkg::STATUS_MISS;
						state_d        = oaht_pkg::S_DONE;
					end else if (!st.tomb && st.key_eq) begin
						cmd.write_rem  = (st.func == oaht_pkg::FUNC_REMOVE);
						cmd.finish     = 1'b1;
						cmd.fin_status = oaht_pkg::STATUS_OK;
						state_d        = oaht_pkg::S_DONE;
					end else if (st.last) begin
						cmd.finish     = 1'b1;
						cmd.fin_status = oaht_pkg::STATUS_MISS;
						state_d        = oaht_pkg::S_DONE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = oaht_pkg::S_READ;
					end
				end
			end
			oaht_pkg::S_DONE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = oaht_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = oaht_pkg::S_CLEAR;
			end
		endcase
	end

endmodule

FILE: src/oaht_dp.sv
// Datapath of the hash table unit: hash multiplier, home slot reduction, probe
// stepping, slot memories, counters and the output word register. Uses oaht_pkg.
module oaht_dp #(
	parameter int TABLE_SLOTS  = oaht_pkg::DEF_TABLE_SLOTS,
	parameter int PAYLOAD_BITS = oaht_pkg::DEF_PAYLOAD_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  oaht_pkg::cmd_t                   cmd,
	output oaht_pkg::stat_t                  st,
	input  logic [oaht_pkg::S_TDATA_W-1:0]   in_data,
	input  logic [oaht_pkg::FUNC_W-1:0]      in_user,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [oaht_pkg::M_TDATA_W-1:0]   out_data,
	output logic [oaht_pkg::STATUS_W-1:0]    out_user
);

	localparam int IDX_W   = $clog2(TABLE_SLOTS);
	localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
	localparam int ENTRY_W = oaht_pkg::KEY_W + PAYLOAD_BITS;
	localparam bit POW2    = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
	localparam logic [IDX_W:0]   SLOTS_X   = (IDX_W + 1)'(TABLE_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [IDX_W-1:0] STEP0     = IDX_W'(2 % TABLE_SLOTS);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_SLOTS);
	localparam logic [oaht_pkg::COLL_W-1:0] COLL_MAX = '1;

	// Captured operation.
	logic [oaht_pkg::FUNC_W-1:0]   func_q;
	logic [oaht_pkg::KEY_W-1:0]    key_q;
	logic [oaht_pkg::PAY_IO_W-1:0] pay_q;

	// Hash accumulation.
	logic [1:0]                   hcnt_q;
	logic [oaht_pkg::HASH_W-1:0]  prod_s1;
	logic [oaht_pkg::HASH_W-1:0]  h_q;

	// Probe walk: slot, step 2(i+1) mod size, probe number.
	logic [IDX_W-1:0] s_q, d_q, i_q, clr_q;
	logic [IDX_W-1:0] home_c;
	logic             red_last;
	logic [IDX_W:0]   s_sum, d_sum;
	logic [IDX_W-1:0] s_nxt, d_nxt;

	logic [CNT_W-1:0]            live_q;
	logic [oaht_pkg::COLL_W-1:0] coll_q;
	logic [oaht_pkg::STATUS_W-1:0] res_status_q;

	oaht_pkg::flags_t   flags_mem [TABLE_SLOTS];
	logic [ENTRY_W-1:0] entry_mem [TABLE_SLOTS];
	oaht_pkg::flags_t   flags_rd_q;
	logic [ENTRY_W-1:0] entry_rd_q;

	logic [63:0]                      pay_ext, rd_ext;
	logic [PAYLOAD_BITS-1:0]          rd_pay;
	logic [oaht_pkg::KEY_W-1:0]       rd_key;
	logic [31:0]                      slot_ext, cnt_ext;
	logic [oaht_pkg::SLOT_OUT_W-1:0]  slot_out;
	logic [oaht_pkg::PAY_IO_W-1:0]    pay_out;
	logic                             res_ok, res_hit;

	logic                            m_valid_q;
	logic [oaht_pkg::M_TDATA_W-1:0]  m_data_q;
	logic [oaht_pkg::STATUS_W-1:0]   m_user_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_user;
			key_q  <= in_data[oaht_pkg::KEY_W-1:0];
			pay_q  <= in_data[oaht_pkg::KEY_W +: oaht_pkg::PAY_IO_W];
		end
	end

	// Three products go through one multiplier; each is registered, then XORed into the hash.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hcnt_q <= '0;
			h_q    <= '0;
		end else if (cmd.hash) begin
			hcnt_q <= hcnt_q + 2'd1;
			if (hcnt_q != 2'd3) begin
				prod_s1 <= oaht_pkg::HASH_W'(key_q) *
					oaht_pkg::HASH_W'(oaht_pkg::hash_const(hcnt_q));
			end
			if (hcnt_q != 2'd0) begin
				h_q <= h_q ^ prod_s1;
			end
		end
	end

	generate
		if (POW2) begin : g_mask
			assign home_c   = h_q[IDX_W-1:0];
			assign red_last = 1'b1;
		end else begin : g_recip
			// Remainder by the table size over four 16-bit digits of the hash, top
			// digit first. Each digit steps through a product with a scaled
			// reciprocal, estimated quotient times the size, then subtract and one
			// correction, since the estimate is low by at most one.
			localparam logic [63:0] RECIP    = (64'd1 << (31 + IDX_W)) / 64'(TABLE_SLOTS);
			localparam logic [31:0] RECIP_32 = RECIP[31:0];
			localparam logic [31:0] SLOTS_32 = 32'(TABLE_SLOTS);
			logic [1:0]  dig_q, ph_q;
			logic [15:0] r_q;
			logic [63:0] h_ext, rcp_s1, q_c;
			logic [31:0] t_c, qn_s2, diff_c, rem_c;

			assign h_ext    = 64'(h_q);
			assign t_c      = {r_q, h_ext[{~dig_q, 4'b0000} +: 16]};
			assign q_c      = rcp_s1 >> (31 + IDX_W);
			assign diff_c   = t_c - qn_s2;
			assign rem_c    = (diff_c >= SLOTS_32) ? (diff_c - SLOTS_32) : diff_c;
			assign home_c   = rem_c[IDX_W-1:0];
			assign red_last = (dig_q == 2'd3) && (ph_q == 2'd2);

			always_ff @(posedge clk) begin
				if (cmd.capture) begin
					dig_q <= '0;
					ph_q  <= '0;
					r_q   <= '0;
				end else if (cmd.reduce) begin
					if (ph_q == 2'd2) begin
						ph_q  <= '0;
						dig_q <= dig_q + 2'd1;
						r_q   <= rem_c[15:0];
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (cmd.reduce) begin
					rcp_s1 <= 64'(t_c) * 64'(RECIP_32);
					qn_s2  <= q_c[31:0] * SLOTS_32;
				end
			end
		end
	endgenerate

	assign s_sum = {1'b0, s_q} + {1'b0, d_q};
	assign s_nxt = (s_sum >= SLOTS_X) ? IDX_W'(s_sum - SLOTS_X) : s_sum[IDX_W-1:0];
	assign d_sum = {1'b0, d_q} + (IDX_W + 1)'(2);
	assign d_nxt = (d_sum >= SLOTS_X) ? IDX_W'(d_sum - SLOTS_X) : d_sum[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.reduce && red_last) begin
			s_q <= home_c;
			d_q <= STEP0;
			i_q <= '0;
		end else if (cmd.advance) begin
			s_q <= s_nxt;
			d_q <= d_nxt;
			i_q <= i_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= (clr_q == LAST_IDX) ? '0 : clr_q + IDX_W'(1);
		end
	end

	assign pay_ext = 64'(pay_q);

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			flags_mem[clr_q] <= '0;
		end else if (cmd.write_ins) begin
			flags_mem[s_q] <= '{used: 1'b1, tomb: 1'b0};
		end else if (cmd.write_rem) begin
			flags_mem[s_q] <= '{used: 1'b1, tomb: 1'b1};
		end
		if (cmd.read) begin
			flags_rd_q <= flags_mem[s_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_ins) begin
			entry_mem[s_q] <= {key_q, pay_ext[PAYLOAD_BITS-1:0]};
		end
		if (cmd.read) begin
			entry_rd_q <= entry_mem[s_q];
		end
	end

	assign rd_key = entry_rd_q[ENTRY_W-1 -: oaht_pkg::KEY_W];
	assign rd_pay = entry_rd_q[PAYLOAD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			coll_q <= '0;
		end else if (cmd.write_ins) begin
			live_q <= live_q + CNT_W'(1);
			if (i_q != '0 && coll_q != COLL_MAX) begin
				coll_q <= coll_q + oaht_pkg::COLL_W'(1);
			end
		end else if (cmd.write_rem && live_q != '0) begin
			live_q <= live_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_status_q <= cmd.fin_status;
		end
	end

	// Slot and probe data stay put between the finishing check and the emit.
	assign res_ok   = (res_status_q == oaht_pkg::STATUS_OK);
	assign res_hit  = res_ok && (func_q != oaht_pkg::FUNC_INSERT);
	assign slot_ext = res_ok ? 32'(s_q) : '0;
	assign slot_out = slot_ext[oaht_pkg::SLOT_OUT_W-1:0];
	assign rd_ext   = 64'(rd_pay);
	assign pay_out  = res_hit ? rd_ext[oaht_pkg::PAY_IO_W-1:0] : '0;
	assign cnt_ext  = 32'(live_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (out_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_user_q <= res_status_q;
			m_data_q <= {3'b000, coll_q, cnt_ext[oaht_pkg::COUNT_OUT_W-1:0], pay_out, slot_out};
		end
	end

	assign out_valid = m_valid_q;
	assign out_data  = m_data_q;
	assign out_user  = m_user_q;

	assign st.clear_done  = (clr_q == LAST_IDX);
	assign st.func        = func_q;
	assign st.full        = (live_q == FULL_CNT);
	assign st.hash_done   = (hcnt_q == 2'd3);
	assign st.reduce_done = red_last;
	assign st.used        = flags_rd_q.used;
	assign st.tomb        = flags_rd_q.tomb;
	assign st.key_eq      = (rd_key == key_q);
	assign st.last        = (i_q == LAST_IDX);
	assign st.out_free    = !m_valid_q || out_ready;

endmodule

FILE: src/open_address_hash_table_unit.sv
// Top level of the open-address hash table unit with quadratic probing.
// Instantiates oaht_ctrl and oaht_dp; types and constants come from oaht_pkg.
//
//  channel | direction | tuser       | tdata (lowest bit first)
//  s_*     | in        | func [1:0]  | key [30:0], entry_payload [62:31]
//  m_*     | out       | status[1:0] | slot_index [9:0], found_payload [41:10],
//          |           |             | element_count [52:42], collision_count [84:53]
//
// An insert, find or remove hashes the key, reduces the hash to a home slot
// (a mask when TABLE_SLOTS is a power of two, else a reciprocal remainder)
// and probes; each probe is a read of the slot memories followed by a check.
// An unknown func or an insert into a full table finishes without a probe.
// After reset a clearing pass empties the slot flags before the first word
// is accepted. A finished word waits in the output register while the next
// word is accepted.
module open_address_hash_table_unit #(
	parameter int TABLE_SLOTS  = oaht_pkg::DEF_TABLE_SLOTS,
	parameter int PAYLOAD_BITS = oaht_pkg::DEF_PAYLOAD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [oaht_pkg::S_TDATA_W-1:0] s_tdata,  // key, entry_payload
	input  logic [oaht_pkg::FUNC_W-1:0]    s_tuser,  // func
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [oaht_pkg::M_TDATA_W-1:0] m_tdata,  // slot_index, found_payload,
	                                                 // element_count, collision_count
	output logic [oaht_pkg::STATUS_W-1:0]  m_tuser   // status
);

	oaht_pkg::cmd_t  cmd;
	oaht_pkg::stat_t st;

	oaht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	oaht_dp #(
		.TABLE_SLOTS  (TABLE_SLOTS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule
